FILE: src/lfa_pkg.sv
`timescale 1ns / 1ps

package lfa_pkg;

    // Counter width default
    localparam int DEFAULT_COUNT_BITS = 20;

    // Fixed-point constants
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [31:0] ONE_Q16 = 32'd65536;

    // Loss mode codes
    localparam logic [1:0] MODE_SQ_ERR  = 2'd0;
    localparam logic [1:0] MODE_ABS_ERR = 2'd1;
    localparam logic [1:0] MODE_XENT    = 2'd2;
    localparam logic [1:0] MODE_BIN_LOG = 2'd3;

    // Register index of loss_mode
    localparam logic REG_LOSS_MODE = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CALC,
        ST_MSQ,
        ST_NORM,
        ST_SQR,
        ST_LNMUL,
        ST_TMUL,
        ST_ACCUM,
        ST_DIVSET,
        ST_DIV,
        ST_DONE
    } lfa_state_t;

endpackage

FILE: src/loss_function_accumulator_unit.sv
`timescale 1ns / 1ps
// In cross entropy and binary log loss the log cost of a pair is set by one 34x34 multiplier
// used for 16 squarings.
// For a last pair the mean comes from a restoring divider, one quotient bit a cycle.
// The input is not ready while a pair is being worked on.
// Reset (aresetn low, synchronous): mode 0, accumulator, counter and flags cleared.
module loss_function_accumulator_unit #(
    parameter int COUNT_BITS = lfa_pkg::DEFAULT_COUNT_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_true_value,
    input  logic signed [31:0] s_predicted_value,
    input  logic               s_last_pair,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_mean_loss,
    output logic        [19:0] m_pair_count,
    output logic               m_saturated,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [2:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);
    import lfa_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    lfa_state_t state_reg, state_next;

    logic        [1:0]            mode_reg;
    logic signed [31:0]           y_reg, y_next;
    logic signed [31:0]           p_reg, p_next;
    logic                         last_reg, last_next;
    logic        [31:0]           ad_reg, ad_next;
    logic        [31:0]           pc_reg, pc_next;
    logic        [31:0]           m_reg, m_next;
    logic        [4:0]            shamt_reg, shamt_next;
    logic        [15:0]           frac_reg, frac_next;
    logic        [5:0]            step_reg, step_next;
    logic                         pass_reg, pass_next;
    logic signed [33:0]           ln_reg, ln_next;
    logic signed [65:0]           term_reg, term_next;
    logic signed [63:0]           sum_reg, sum_next;
    logic        [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                         ovf_reg, ovf_next;
    logic        [63:0]           quo_reg, quo_next;
    logic        [COUNT_BITS-1:0] rem_reg, rem_next;
    logic                         neg_reg, neg_next;
    logic                         m_valid_reg, m_valid_next;
    logic signed [31:0]           mean_reg, mean_next;
    logic        [19:0]           pcnt_reg, pcnt_next;
    logic                         sat_reg, sat_next;

    // Shared multiplier
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;

    logic signed [32:0]       diff;
    logic        [31:0]       sq;
    logic        [5:0]        lg_hi;
    logic signed [67:0]       ln_sum;
    logic signed [65:0]       term_shr;
    logic signed [63:0]       term64;
    logic signed [64:0]       acc_sum;
    logic        [COUNT_BITS:0] trial;
    logic                     norm_zero;
    logic        [4:0]        norm_step;
    logic                     out_free;
    logic                     cfg_write;

    assign mul_p     = mul_a * mul_b;
    assign diff      = 33'(y_reg) - 33'(p_reg);
    assign sq        = mul_p[61:30];
    assign lg_hi     = 6'd14 - {1'b0, shamt_reg};
    assign ln_sum    = mul_p + (68'sd1 <<< 31);
    assign term_shr  = term_reg >>> 16;
    assign term64    = mode_reg[1] ? term_shr[63:0] : term_reg[63:0];
    assign acc_sum   = {sum_reg[63], sum_reg} + {term64[63], term64};
    assign trial     = {rem_reg, quo_reg[63]};
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_write = psel && penable && pwrite && pready;

    // Zero test and shift amount of the current normalization step
    always_comb begin
        case (step_reg[2:0])
            3'd0:    begin norm_zero = (m_reg[30:15] == '0); norm_step = 5'd16; end
            3'd1:    begin norm_zero = (m_reg[30:23] == '0); norm_step = 5'd8;  end
            3'd2:    begin norm_zero = (m_reg[30:27] == '0); norm_step = 5'd4;  end
            3'd3:    begin norm_zero = (m_reg[30:29] == '0); norm_step = 5'd2;  end
            default: begin norm_zero = !m_reg[30];           norm_step = 5'd1;  end
        endcase
    end

    // Select multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MSQ: begin
                mul_a = $signed({2'b00, ad_reg});
                mul_b = $signed({2'b00, ad_reg});
            end
            ST_SQR: begin
                mul_a = $signed({2'b00, m_reg});
                mul_b = $signed({2'b00, m_reg});
            end
            ST_LNMUL: begin
                mul_a = $signed({{12{lg_hi[5]}}, lg_hi, frac_reg});
                mul_b = $signed({2'b00, LN2_Q32});
            end
            ST_TMUL: begin
                mul_a = pass_reg ? ($signed({2'b00, ONE_Q16}) - 34'(y_reg)) : 34'(y_reg);
                mul_b = ln_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_CALC;
            ST_CALC: begin
                unique case (mode_reg)
                    MODE_SQ_ERR:  state_next = ST_MSQ;
                    MODE_ABS_ERR: state_next = ST_ACCUM;
                    default:      state_next = ST_NORM;
                endcase
            end
            ST_MSQ:    state_next = ST_ACCUM;
            ST_NORM:   if (step_reg == 6'd4) state_next = ST_SQR;
            ST_SQR:    if (step_reg == 6'd15) state_next = ST_LNMUL;
            ST_LNMUL:  state_next = ST_TMUL;
            ST_TMUL: begin
                if (mode_reg == MODE_BIN_LOG && !pass_reg) state_next = ST_NORM;
                else state_next = ST_ACCUM;
            end
            ST_ACCUM:  state_next = last_reg ? ST_DIVSET : ST_IDLE;
            ST_DIVSET: state_next = ST_DIV;
            ST_DIV:    if (step_reg == 6'd63) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        y_next       = y_reg;
        p_next       = p_reg;
        last_next    = last_reg;
        ad_next      = ad_reg;
        pc_next      = pc_reg;
        m_next       = m_reg;
        shamt_next   = shamt_reg;
        frac_next    = frac_reg;
        step_next    = step_reg;
        pass_next    = pass_reg;
        ln_next      = ln_reg;
        term_next    = term_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        mean_next    = mean_reg;
        pcnt_next    = pcnt_reg;
        sat_next     = sat_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE: begin
                // capture the pair
                if (s_valid) begin
                    y_next    = s_true_value;
                    p_next    = s_predicted_value;
                    last_next = s_last_pair;
                end
            end
            ST_CALC: begin
                // absolute difference and clipped probability
                ad_next = diff[32] ? 32'(-diff) : diff[31:0];
                if (p_reg < 32'sd1) begin
                    pc_next = 32'd1;
                end else if (mode_reg == MODE_BIN_LOG && p_reg > 32'sd65535) begin
                    pc_next = 32'd65535;
                end else begin
                    pc_next = p_reg;
                end
                m_next     = pc_next;
                term_next  = {34'd0, ad_next};
                shamt_next = '0;
                frac_next  = '0;
                step_next  = '0;
                pass_next  = 1'b0;
            end
            ST_MSQ: begin
                term_next = {18'd0, mul_p[63:16]};
            end
            ST_NORM: begin
                // shift the leading one up to bit 30
                if (norm_zero) begin
                    m_next     = m_reg << norm_step;
                    shamt_next = shamt_reg + norm_step;
                end
                step_next = (step_reg == 6'd4) ? 6'd0 : step_reg + 6'd1;
            end
            ST_SQR: begin
                // one log2 fraction bit per squaring
                if (sq[31]) begin
                    m_next = sq >> 1;
                    frac_next[4'd15 - step_reg[3:0]] = 1'b1;
                end else begin
                    m_next = sq;
                end
                step_next = (step_reg == 6'd15) ? 6'd0 : step_reg + 6'd1;
            end
            ST_LNMUL: begin
                ln_next = ln_sum[65:32];
            end
            ST_TMUL: begin
                term_next = pass_reg ? term_reg + mul_p[65:0] : mul_p[65:0];
                if (mode_reg == MODE_BIN_LOG && !pass_reg) begin
                    pass_next  = 1'b1;
                    m_next     = ONE_Q16 - pc_reg;
                    shamt_next = '0;
                    frac_next  = '0;
                    step_next  = '0;
                end
            end
            ST_ACCUM: begin
                // saturating accumulate and count
                if (acc_sum[64] != acc_sum[63]) begin
                    sum_next = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                    ovf_next = 1'b1;
                end else begin
                    sum_next = acc_sum[63:0];
                end
                if (cnt_reg == CNT_MAX) ovf_next = 1'b1;
                else cnt_next = cnt_reg + 1'b1;
            end
            ST_DIVSET: begin
                quo_next  = sum_reg[63] ? 64'(-sum_reg) : sum_reg;
                rem_next  = '0;
                step_next = '0;
                neg_next  = sum_reg[63] ^ mode_reg[1];
            end
            ST_DIV: begin
                // one restoring quotient bit
                if (trial >= {1'b0, cnt_reg}) begin
                    rem_next = COUNT_BITS'(trial - {1'b0, cnt_reg});
                    quo_next = {quo_reg[62:0], 1'b1};
                end else begin
                    rem_next = trial[COUNT_BITS-1:0];
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                step_next = step_reg + 6'd1;
            end
            ST_DONE: begin
                // clamp, load the result register and clear the vector state
                if (out_free) begin
                    sat_next = ovf_reg;
                    if (neg_reg) begin
                        if (quo_reg > 64'h8000_0000) begin
                            mean_next = 32'sh8000_0000;
                            sat_next  = 1'b1;
                        end else begin
                            mean_next = 32'(-quo_reg[31:0]);
                        end
                    end else begin
                        if (quo_reg > 64'h7FFF_FFFF) begin
                            mean_next = 32'sh7FFF_FFFF;
                            sat_next  = 1'b1;
                        end else begin
                            mean_next = quo_reg[31:0];
                        end
                    end
                    pcnt_next    = 20'(cnt_reg);
                    m_valid_next = 1'b1;
                    sum_next     = '0;
                    cnt_next     = '0;
                    ovf_next     = 1'b0;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_SQ_ERR;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            if (cfg_write && paddr[2] == REG_LOSS_MODE) mode_reg <= pwdata[1:0];
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        y_reg     <= y_next;
        p_reg     <= p_next;
        last_reg  <= last_next;
        ad_reg    <= ad_next;
        pc_reg    <= pc_next;
        m_reg     <= m_next;
        shamt_reg <= shamt_next;
        frac_reg  <= frac_next;
        step_reg  <= step_next;
        pass_reg  <= pass_next;
        ln_reg    <= ln_next;
        term_reg  <= term_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
        mean_reg  <= mean_next;
        pcnt_reg  <= pcnt_next;
        sat_reg   <= sat_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_mean_loss  = mean_reg;
    assign m_pair_count = pcnt_reg;
    assign m_saturated  = sat_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == REG_LOSS_MODE) ? {30'd0, mode_reg} : 32'd0;

endmodule

FILE: src/lfa_checker.sv
`timescale 1ns / 1ps
module lfa_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_mean_loss,
    input logic               pready
);

    // Drop ready for the cycle after a transfer
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready after transfer");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mean_loss))
        else $error("result changed while stalled");

    // A result appears only out of a busy phase
    a_out_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without work");

    // Keep the configuration port ready
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind loss_function_accumulator_unit lfa_checker u_lfa_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_mean_loss (m_mean_loss),
    .pready      (pready)
);
